// ===== design/priority_active_expired_scheduler_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the priority active/expired scheduler
// Concurrent checks that are compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_ACTIVE_EXPIRED_SCHEDULER_ASSERT_SVH
`define PRIORITY_ACTIVE_EXPIRED_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property that must hold on every clock edge outside reset
`define PAES_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition in any cycle implies a consequence in the next
`define PAES_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PAES_ASSERT(lbl, clk, rstn, prop, msg)
`define PAES_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/paes_pkg.sv =====
// ---------------------------------------------------------------------------
// Scheduler package
// Sizes, codes and shared types of the active/expired ready-queue engine.
// ---------------------------------------------------------------------------
package paes_pkg;

  localparam int LIST_DEPTH  = 64;
  localparam int PRIO_LEVELS = 4;

  localparam int ID_W   = 6;
  localparam int DYN_W  = 3;
  localparam int BASE_W = 3;
  localparam int PRIO_W = $clog2(PRIO_LEVELS);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int PRIO_MAX = PRIO_LEVELS - 1;

  localparam int IN_TDATA_W  = ((ID_W + DYN_W + BASE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ID_W + PRIO_W + 1 + 7) / 8) * 8;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_GET = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // One command broadcast to every cell of a list
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t entry;
  } list_cmd_t;

endpackage

// ===== design/priority_active_expired_scheduler.sv =====
// ---------------------------------------------------------------------------
// Priority active/expired scheduler
// Ready-queue engine with two sorted lists that swap roles when drained.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser selects add or get, tdata holds the
//   process id, dynamic and static priority. An add with dynamic priority
//   -1 goes to the expired list at static priority minus one, any other add
//   to the active list. A get pops the head of the active list, swapping
//   the lists first when the active one is empty.
//   m_axis returns exactly one result per request: status in tuser, the
//   id, priority and expired flag in tdata.
//   Each list is a row of cells that shifts as a whole, so an insert or a
//   pop finishes in the accepting cycle; the result is registered and shows
//   up in the cycle after the transfer. One request per cycle is taken while
//   the output register is empty or being drained.
//   When m_axis stalls, the result holds and s_axis tready drops.
//   Reset empties both lists and makes list a active; no clearing pass.
// ---------------------------------------------------------------------------
`include "priority_active_expired_scheduler_assert.svh"

module priority_active_expired_scheduler
  import paes_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // proc_id, dyn_prio, base_prio
  input  logic                   s_axis_tuser,   // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_id, out_prio, to_expired
  output logic [1:0]             m_axis_tuser    // status
);

  logic                proc_accept;
  req_e                req;
  logic [ID_W-1:0]     in_id;
  logic [DYN_W-1:0]    in_dyn;
  logic [BASE_W-1:0]   in_base;

  logic                a_active_q, a_active_d;
  list_cmd_t           cmd_a, cmd_b;
  entry_t              head_a, head_b;
  logic [CNT_W-1:0]    cnt_a, cnt_b;
  logic [CNT_W-1:0]    act_cnt, exp_cnt;

  logic                expired;
  logic [PRIO_W-1:0]   add_prio;
  logic                tgt_a;
  logic                swap_a;
  logic [CNT_W-1:0]    tgt_cnt;
  logic [CNT_W-1:0]    get_cnt;
  entry_t              new_entry;

  status_e             status_d, status_q;
  logic [ID_W-1:0]     id_d, id_q;
  logic [PRIO_W-1:0]   prio_d, prio_q;
  logic                exp_d, exp_q;
  logic                out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign proc_accept   = s_axis_tvalid && s_axis_tready;

  assign req     = req_e'(s_axis_tuser);
  assign in_id   = s_axis_tdata[ID_W-1:0];
  assign in_dyn  = s_axis_tdata[ID_W+DYN_W-1:ID_W];
  assign in_base = s_axis_tdata[ID_W+DYN_W+BASE_W-1:ID_W+DYN_W];

  assign act_cnt = a_active_q ? cnt_a : cnt_b;
  assign exp_cnt = a_active_q ? cnt_b : cnt_a;

  // Saturate the stored priority into the list range
  assign expired = (in_dyn == '1);
  always_comb begin
    if (expired) begin
      if (in_base == '0) begin
        add_prio = '0;
      end else if (32'(in_base) >= PRIO_LEVELS) begin
        add_prio = PRIO_W'(PRIO_MAX);
      end else begin
        add_prio = PRIO_W'(in_base - BASE_W'(1));
      end
    end else if (in_dyn[DYN_W-1]) begin
      add_prio = '0;
    end else if (32'(in_dyn) > PRIO_MAX) begin
      add_prio = PRIO_W'(PRIO_MAX);
    end else begin
      add_prio = PRIO_W'(in_dyn);
    end
  end

  assign new_entry.id   = in_id;
  assign new_entry.prio = add_prio;

  assign tgt_a   = expired ? !a_active_q : a_active_q;
  assign tgt_cnt = tgt_a ? cnt_a : cnt_b;

  // Swap roles when the active list has drained
  assign swap_a  = (act_cnt == '0) ? !a_active_q : a_active_q;
  assign get_cnt = (act_cnt == '0) ? exp_cnt : act_cnt;

  always_comb begin
    cmd_a      = '0;
    cmd_b      = '0;
    cmd_a.entry = new_entry;
    cmd_b.entry = new_entry;
    a_active_d = a_active_q;
    status_d   = ST_DONE;
    id_d       = '0;
    prio_d     = '0;
    exp_d      = 1'b0;
    if (proc_accept) begin
      unique case (req)
        REQ_ADD: begin
          id_d   = in_id;
          prio_d = add_prio;
          exp_d  = expired;
          if (tgt_cnt == CNT_W'(LIST_DEPTH)) begin
            status_d = ST_FULL;
          end else if (tgt_a) begin
            cmd_a.ins = 1'b1;
          end else begin
            cmd_b.ins = 1'b1;
          end
        end
        REQ_GET: begin
          a_active_d = swap_a;
          if (get_cnt == '0) begin
            status_d = ST_EMPTY;
          end else if (swap_a) begin
            cmd_a.pop = 1'b1;
            id_d      = head_a.id;
            prio_d    = head_a.prio;
          end else begin
            cmd_b.pop = 1'b1;
            id_d      = head_b.id;
            prio_d    = head_b.prio;
          end
        end
        default: ;
      endcase
    end
  end

  paes_list u_list_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_a),
    .head_o  (head_a),
    .count_o (cnt_a)
  );

  paes_list u_list_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_b),
    .head_o  (head_b),
    .count_o (cnt_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_active_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      a_active_q <= a_active_d;
      if (proc_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until the transfer
  always_ff @(posedge clk_i) begin
    if (proc_accept) begin
      status_q <= status_d;
      id_q     <= id_d;
      prio_q   <= prio_d;
      exp_q    <= exp_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = OUT_TDATA_W'({exp_q, prio_q, id_q});

  `PAES_ASSERT(a_cnt_bound, clk_i, rst_ni, (cnt_a <= CNT_W'(LIST_DEPTH)) && (cnt_b <= CNT_W'(LIST_DEPTH)), "list count above depth")
  `PAES_ASSERT(a_empty_status, clk_i, rst_ni, !(out_valid_q && (status_q == ST_EMPTY)) || ((cnt_a == '0) && (cnt_b == '0)), "empty status with entries stored")
  `PAES_ASSERT_NEXT(a_result_after_accept, clk_i, rst_ni, proc_accept, out_valid_q, "accepted request left no result")

endmodule

// ===== design/paes_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted list cell
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor, on pop it takes its right neighbor.
// ---------------------------------------------------------------------------
module paes_cell
  import paes_pkg::*;
(
  input  logic      clk_i,
  input  list_cmd_t cmd_i,
  input  logic      valid_i,       // cell lies below the fill count
  input  logic      prev_gt_i,     // left neighbor moves right on insert
  input  entry_t    prev_entry_i,
  input  entry_t    next_entry_i,
  output logic      gt_o,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;

  // New entry outranks this one: this one has to move right
  assign gt_o = valid_i && (cmd_i.entry.prio > entry_q.prio);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (prev_gt_i) begin
        entry_d = prev_entry_i;
      end else if (gt_o || !valid_i) begin
        entry_d = cmd_i.entry;
      end
    end else if (cmd_i.pop) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== design/paes_list.sv =====
// ---------------------------------------------------------------------------
// Sorted list
// Row of cells kept in descending priority, arrival order among equals,
// with its fill count. Each insert or pop updates every cell and the count together.
// ---------------------------------------------------------------------------
module paes_list
  import paes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  list_cmd_t        cmd_i,
  output entry_t           head_o,
  output logic [CNT_W-1:0] count_o
);

  logic [CNT_W-1:0] count_q, count_d;
  entry_t           entries [LIST_DEPTH];
  logic             gts     [LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    entry_t prev_entry;
    entry_t next_entry;
    logic   prev_gt;

    if (i == 0) begin : g_first
      assign prev_entry = cmd_i.entry;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_entry = entries[i-1];
      assign prev_gt    = gts[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign next_entry = entries[i];
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    paes_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd_i),
      .valid_i      (count_q > CNT_W'(i)),
      .prev_gt_i    (prev_gt),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .gt_o         (gts[i]),
      .entry_o      (entries[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = entries[0];
  assign count_o = count_q;

endmodule
